FILE: rtl/core/four_square_cipher_macros.svh
// assertion helpers shared by the checker files
`ifndef FOUR_SQUARE_CIPHER_MACROS_SVH
`define FOUR_SQUARE_CIPHER_MACROS_SVH

// same-cycle implication or plain property, sampled on i_clk, off in reset
`define FSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// next-cycle implication, sampled on i_clk, off in reset
`define FSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);

`endif

FILE: rtl/core/fsc_pkg.sv
`default_nettype none

package fsc_pkg;

    localparam int CELLS     = 25;
    localparam int MEM_DEPTH = 2 * CELLS;

    localparam logic [4:0] PAD_INDEX   = 5'd22;
    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;
    localparam logic       STATUS_OK   = 1'b0;
    localparam logic       STATUS_BAD  = 1'b1;

    typedef enum logic [1:0] {
        OP_KEY_CHAR = 2'd0,
        OP_KEY_END  = 2'd1,
        OP_MSG_CHAR = 2'd2,
        OP_MSG_END  = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       square_sel;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [7:0] letter;
        logic       last;
        logic       status;
    } t_out_item;

    // {valid, alphabet index} of a lowercase ascii letter
    function automatic logic [5:0] f_index(logic [7:0] c);
        logic       ok;
        logic [4:0] idx;
        ok  = (c >= 8'h61) && (c <= 8'h7a) && (c != 8'h71);
        idx = (c < 8'h71) ? 5'(c - 8'h61) : 5'(c - 8'h62);
        return {ok, idx};
    endfunction

    function automatic logic [7:0] f_letter(logic [4:0] idx);
        logic [7:0] res;
        if (idx < 5'd16) begin
            res = 8'h61 + {3'b000, idx};
        end else if (idx < 5'(CELLS)) begin
            res = 8'h62 + {3'b000, idx};
        end else begin
            res = 8'h00;
        end
        return res;
    endfunction

    function automatic logic [2:0] f_row(logic [4:0] v);
        logic [2:0] r;
        if (v >= 5'd20) begin
            r = 3'd4;
        end else if (v >= 5'd15) begin
            r = 3'd3;
        end else if (v >= 5'd10) begin
            r = 3'd2;
        end else if (v >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [2:0] f_col(logic [4:0] v);
        logic [2:0] r;
        r = f_row(v);
        return 3'(v - {r, 2'b00} - {2'b00, r});
    endfunction

    function automatic logic [4:0] f_cell(logic [2:0] row, logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    // square one lives in the lower half of each memory, square two in the upper
    function automatic logic [5:0] f_addr(logic sel, logic [4:0] v);
        return sel ? ({1'b0, v} + 6'(CELLS)) : {1'b0, v};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/four_square_cipher.sv
// Four-square cipher over the 25-letter alphabet without q. Key character
// transactions add a new letter to the selected keyed square; a key end
// transaction fills the rest of that square in alphabet order and holds the
// input stalled while it walks the alphabet letters. Message characters that
// open a pair, are skipped or are rejected are handled in the idle state. The
// character that completes a pair, or a message end that pads a held letter
// with x, first reads the square and position memories into registers, then
// sends each output letter in turn through the output register. Output stall
// holds each letter until the output register is free. The mode register is
// written through the configuration channel, which is always ready, and must
// only change while the block is idle. Squares must be completed before
// message characters are sent; no clearing pass follows reset.
`default_nettype none

module four_square_cipher import fsc_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire logic      i_out_stall,
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_data,
    output logic           o_cfg_ready
);

    localparam logic [7:0] SYM_SPACE   = 8'h20;
    localparam logic [7:0] SYM_UPPER_A = 8'h41;
    localparam logic [7:0] SYM_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_PAIR0,
        S_PAIR1
    } t_state;

    t_state            r_state;
    logic [4:0]        r_cnt;
    logic              r_fill_sel;
    logic              r_holding;
    logic [4:0]        r_held;
    logic [1:0][24:0]  r_present;
    logic [1:0][4:0]   r_fill;
    logic              r_mode;
    logic              r_pair_mode;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [4:0] mem_sq  [MEM_DEPTH];
    logic [4:0] mem_pos [MEM_DEPTH];
    logic [4:0] r_sq_a, r_sq_b, r_pos_a, r_pos_b;

    logic       out_free, in_acc, out_load;
    logic [7:0] msg_sym;
    logic [5:0] key_lookup, msg_lookup;
    logic       msg_skip, msg_ok, pair_go;
    logic [4:0] pair_b;
    logic [5:0] rd_addr_a, rd_addr_b;
    logic       place_en, place_sel, place_ok;
    logic [4:0] place_idx;
    logic [4:0] res_x, res_y;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        msg_sym = i_in_data.symbol;
        if (r_mode == MODE_ENCODE && i_in_data.symbol >= SYM_UPPER_A &&
            i_in_data.symbol <= SYM_UPPER_Z) begin
            msg_sym = i_in_data.symbol + CASE_OFFSET;
        end
    end

    assign key_lookup = f_index(i_in_data.symbol);
    assign msg_lookup = f_index(msg_sym);
    assign msg_skip   = (r_mode == MODE_ENCODE) && (i_in_data.symbol == SYM_SPACE);
    assign msg_ok     = msg_lookup[5];

    assign pair_go = in_acc && r_holding &&
                     ((i_in_data.op == OP_MSG_CHAR && !msg_skip && msg_ok) ||
                      (i_in_data.op == OP_MSG_END));
    assign pair_b  = (i_in_data.op == OP_MSG_END) ? PAD_INDEX : msg_lookup[4:0];

    // output register takes a new transaction this cycle
    assign out_load = ((r_state == S_IDLE) && in_acc && (i_in_data.op == OP_MSG_CHAR) &&
                       !msg_skip && !msg_ok) ||
                      (((r_state == S_PAIR0) || (r_state == S_PAIR1)) && out_free);

    always_comb begin
        if (r_mode == MODE_ENCODE) begin
            rd_addr_a = f_addr(1'b0, f_cell(f_row(r_held), f_col(pair_b)));
            rd_addr_b = f_addr(1'b1, f_cell(f_row(pair_b), f_col(r_held)));
        end else begin
            rd_addr_a = f_addr(1'b0, r_held);
            rd_addr_b = f_addr(1'b1, pair_b);
        end
    end

    // key letter placement, from a key character or the key end walk
    always_comb begin
        place_en  = 1'b0;
        place_sel = i_in_data.square_sel;
        place_idx = key_lookup[4:0];
        if (r_state == S_FILL) begin
            place_en  = 1'b1;
            place_sel = r_fill_sel;
            place_idx = r_cnt;
        end else if (in_acc && i_in_data.op == OP_KEY_CHAR) begin
            place_en = key_lookup[5];
        end
    end

    assign place_ok = place_en && !r_present[place_sel][place_idx] &&
                      (r_fill[place_sel] < 5'(CELLS));

    always_comb begin
        if (r_pair_mode == MODE_ENCODE) begin
            res_x = r_sq_a;
            res_y = r_sq_b;
        end else begin
            res_x = f_cell(f_row(r_pos_a), f_col(r_pos_b));
            res_y = f_cell(f_row(r_pos_b), f_col(r_pos_a));
        end
    end

    always_ff @(posedge i_clk) begin
        if (place_ok) begin
            mem_sq[f_addr(place_sel, r_fill[place_sel])] <= place_idx;
            mem_pos[f_addr(place_sel, place_idx)]        <= r_fill[place_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pair_go) begin
            r_sq_a  <= mem_sq[rd_addr_a];
            r_sq_b  <= mem_sq[rd_addr_b];
            r_pos_a <= mem_pos[rd_addr_a];
            r_pos_b <= mem_pos[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fill_sel  <= 1'b0;
            r_holding   <= 1'b0;
            r_held      <= '0;
            r_present   <= '0;
            r_fill      <= '0;
            r_mode      <= MODE_ENCODE;
            r_pair_mode <= MODE_ENCODE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            if (place_ok) begin
                r_present[place_sel][place_idx] <= 1'b1;
                r_fill[place_sel]               <= r_fill[place_sel] + 5'd1;
            end
            if (pair_go) begin
                r_pair_mode <= r_mode;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in_data.op)
                            OP_KEY_CHAR: begin
                            end
                            OP_KEY_END: begin
                                r_state    <= S_FILL;
                                r_fill_sel <= i_in_data.square_sel;
                                r_cnt      <= '0;
                            end
                            OP_MSG_CHAR: begin
                                if (!msg_skip) begin
                                    if (!msg_ok) begin
                                        r_out_valid <= 1'b1;
                                        r_out <= '{letter: 8'h00, last: 1'b0,
                                                   status: STATUS_BAD};
                                    end else if (!r_holding) begin
                                        r_held    <= msg_lookup[4:0];
                                        r_holding <= 1'b1;
                                    end else begin
                                        r_holding <= 1'b0;
                                        r_state   <= S_PAIR0;
                                    end
                                end
                            end
                            OP_MSG_END: begin
                                if (r_holding) begin
                                    r_holding <= 1'b0;
                                    r_state   <= S_PAIR0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FILL: begin
                    if (r_cnt == 5'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_PAIR0: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out <= '{letter: f_letter(res_x), last: 1'b0,
                                   status: STATUS_OK};
                        r_state <= S_PAIR1;
                    end
                end
                S_PAIR1: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out <= '{letter: f_letter(res_y), last: 1'b1,
                                   status: STATUS_OK};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fsc_checker.sv
`default_nettype none

`include "four_square_cipher_macros.svh"

module fsc_checker import fsc_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire t_in_item  i_in_data,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_item o_out_data,
    input wire logic      i_out_stall
);

    // stalled output transaction holds
    `FSC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "output changed while stalled")

    // rejected symbol reports a lone blank letter
    `FSC_ASSERT(a_bad_format, o_out_valid && o_out_data.status == STATUS_BAD |-> o_out_data.letter == 8'h00 && !o_out_data.last, "malformed error transaction")

    // second letter of a pair is never an error
    `FSC_ASSERT(a_last_ok, o_out_valid && o_out_data.last |-> o_out_data.status == STATUS_OK, "pair end flagged as error")

    // key end starts the fill walk, which blocks input
    `FSC_ASSERT_NEXT(a_fill_stall, i_in_valid && !o_in_stall && i_in_data.op == OP_KEY_END, o_in_stall, "input taken during key fill")

endmodule

bind four_square_cipher fsc_checker u_fsc_checker (.*);

`default_nettype wire
